[rtl/corner_nearest_foreground_pixel_assert.svh]
// Assertion macros used by the corner finder checker.
`ifndef CORNER_NEAREST_FOREGROUND_PIXEL_ASSERT_SVH
`define CORNER_NEAREST_FOREGROUND_PIXEL_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define CNFP_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("corner finder check failed");

// next-cycle implication, sampled on clock, off during reset
`define CNFP_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("corner finder check failed");

`endif

[rtl/cnfp_pkg.sv]
// Shared constants and controller/datapath interface types for the corner finder.
package cnfp_pkg;

   localparam int MAX_DIM_DEF = 64;
   localparam int CFG_W       = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CORNER_W    = 2;
   localparam int OUT_POS_W   = 6;

   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(60);

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = CSR_IDX_W'(1);

   localparam logic [CORNER_W-1:0] CORNER_FIRST = CORNER_W'(0);
   localparam logic [CORNER_W-1:0] CORNER_LAST  = CORNER_W'(3);

   typedef struct packed {
      logic                accept;
      logic                square;
      logic                sqrt_go;
      logic                update;
      logic                advance;
      logic                load_out;
      logic                clear;
      logic [CORNER_W-1:0] corner;
   } cnfp_cmd_type;

   typedef struct packed {
      logic fg_pixel;
      logic sqrt_done;
      logic frame_last;
      logic rsp_taken;
   } cnfp_status_type;

endpackage

[rtl/cnfp_isqrt.sv]
// Iterative ceiling square root, one result bit per cycle, result forced to at least one.
module cnfp_isqrt
   import cnfp_pkg::*;
#(
   parameter int CW = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2*CW:0]     operand,
   output logic              done,
   output logic [CW:0]       ring
);

   localparam int RW   = CW + 1;
   localparam int OPW  = 2 * RW;
   localparam int REMW = RW + 3;
   localparam int CNTW = $clog2(RW + 1);

   logic [OPW-1:0]  op_ff;
   logic [REMW-1:0] rem_ff;
   logic [RW-1:0]   root_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            fin_ff;
   logic            done_ff;
   logic [RW-1:0]   ring_ff;

   logic [REMW-1:0] rem_pre;
   logic [REMW-1:0] trial;
   logic            fits;

   assign rem_pre = {rem_ff[REMW-3:0], op_ff[OPW-1 -: 2]};
   assign trial   = REMW'({root_ff, 2'b01});
   assign fits    = (rem_pre >= trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            op_ff   <= {1'b0, operand};
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= fits ? (rem_pre - trial) : rem_pre;
            root_ff <= {root_ff[RW-2:0], fits};
            op_ff   <= op_ff << 2;
            cnt_ff  <= cnt_ff + CNTW'(1);
            if (cnt_ff == CNTW'(RW - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            done_ff <= 1'b1;
            if (root_ff == '0 && rem_ff == '0) begin
               ring_ff <= RW'(1);
            end else begin
               ring_ff <= root_ff + RW'(rem_ff != '0);
            end
         end
      end
   end

   assign done = done_ff;
   assign ring = ring_ff;

endmodule

[rtl/cnfp_ctrl.sv]
// Sequencer: per-pixel corner loop and four-result drain at frame end.
module cnfp_ctrl
   import cnfp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  cnfp_status_type status,
   output cnfp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_STEP,
      ST_EMIT,
      ST_HOLD
   } state_type;

   state_type           state_ff;
   logic [CORNER_W-1:0] corner_ff;

   always_comb begin
      cmd          = '0;
      cmd.corner   = corner_ff;
      cmd.accept   = req_valid && (state_ff == ST_IDLE);
      cmd.square   = (state_ff == ST_SQUARE);
      cmd.sqrt_go  = (state_ff == ST_ROOT_GO);
      cmd.update   = (state_ff == ST_ROOT_WAIT) && status.sqrt_done;
      cmd.advance  = (state_ff == ST_STEP);
      cmd.load_out = (state_ff == ST_EMIT);
      cmd.clear    = (state_ff == ST_HOLD) && status.rsp_taken && (corner_ff == CORNER_LAST);
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         corner_ff <= CORNER_FIRST;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  corner_ff <= CORNER_FIRST;
                  state_ff  <= status.fg_pixel ? ST_SQUARE : ST_STEP;
               end
            end
            ST_SQUARE: begin
               state_ff <= ST_ROOT_GO;
            end
            ST_ROOT_GO: begin
               state_ff <= ST_ROOT_WAIT;
            end
            ST_ROOT_WAIT: begin
               if (status.sqrt_done) begin
                  if (corner_ff == CORNER_LAST) begin
                     state_ff <= ST_STEP;
                  end else begin
                     corner_ff <= corner_ff + CORNER_W'(1);
                     state_ff  <= ST_SQUARE;
                  end
               end
            end
            ST_STEP: begin
               if (status.frame_last) begin
                  corner_ff <= CORNER_FIRST;
                  state_ff  <= ST_EMIT;
               end else begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_EMIT: begin
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (status.rsp_taken) begin
                  if (corner_ff == CORNER_LAST) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     corner_ff <= corner_ff + CORNER_W'(1);
                     state_ff  <= ST_EMIT;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/cnfp_dp.sv]
// Datapath: config registers, raster position, per-corner best keys, ring unit, result register.
module cnfp_dp
   import cnfp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cnfp_cmd_type         cmd,
   output cnfp_status_type      status,
   input  logic                 req_pixel_on,
   input  logic                 req_frame_last,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CORNER_W-1:0]  rsp_corner_id,
   output logic                 rsp_found,
   output logic [OUT_POS_W-1:0] rsp_hit_row,
   output logic [OUT_POS_W-1:0] rsp_hit_col,
   output logic                 rsp_last_result
);

   localparam int CW = $clog2(MAX_DIM);
   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int SW = 2 * CW + 1;
   localparam int RW = CW + 1;
   localparam int NC = 4;

   function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      if (v == '0) begin
         return DW'(1);
      end else if (32'(v) > MAX_DIM) begin
         return DW'(MAX_DIM);
      end
      return DW'(v);
   endfunction

   function automatic logic [CW-1:0] edge_dist(input logic [CW-1:0] pos,
                                                input logic [DW-1:0] n,
                                                input logic          far_side);
      logic [DW:0] last_pos;
      last_pos = (DW+1)'(n) - (DW+1)'(1);
      if (!far_side) begin
         return pos;
      end else if ((DW+1)'(pos) <= last_pos) begin
         return CW'(last_pos - (DW+1)'(pos));
      end
      return '0;
   endfunction

   logic [CFG_W-1:0] csr_height_ff;
   logic [CFG_W-1:0] csr_width_ff;
   logic [CW-1:0]    row_ff;
   logic [CW-1:0]    col_ff;
   logic             last_ff;
   logic [CW-1:0]    dr_ff;
   logic [CW-1:0]    dc_ff;
   logic [SW-1:0]    d2_ff;

   logic          found_ff [NC];
   logic [RW-1:0] ring_ff  [NC];
   logic [CW-1:0] brow_ff  [NC];
   logic [CW-1:0] bcol_ff  [NC];

   logic                 rsp_valid_ff;
   logic [CORNER_W-1:0]  rsp_corner_id_ff;
   logic                 rsp_found_ff;
   logic [OUT_POS_W-1:0] rsp_hit_row_ff;
   logic [OUT_POS_W-1:0] rsp_hit_col_ff;
   logic                 rsp_last_result_ff;

   logic [DW-1:0]   eff_h;
   logic [DW-1:0]   eff_w;
   logic            in_frame;
   logic            far_r;
   logic            far_c;
   logic [CW-1:0]   dr_now;
   logic [CW-1:0]   dc_now;
   logic [2*CW-1:0] sq_r;
   logic [2*CW-1:0] sq_c;
   logic [SW-1:0]   d2_in;
   logic [DW:0]     col_p1;
   logic [DW:0]     row_p1;
   logic [CW-1:0]   best_dr;
   logic [CW-1:0]   best_dc;
   logic            sqrt_done;
   logic [RW-1:0]   new_ring;
   logic            better;
   logic            rsp_taken;

   assign eff_h    = clamp_dim(csr_height_ff);
   assign eff_w    = clamp_dim(csr_width_ff);
   assign in_frame = ((DW+1)'(row_ff) < (DW+1)'(eff_h)) && ((DW+1)'(col_ff) < (DW+1)'(eff_w));

   assign far_r  = cmd.corner[0];
   assign far_c  = cmd.corner[1];
   assign dr_now = edge_dist(row_ff, eff_h, far_r);
   assign dc_now = edge_dist(col_ff, eff_w, far_c);
   assign sq_r   = dr_now * dr_now;
   assign sq_c   = dc_now * dc_now;
   assign d2_in  = SW'(sq_r) + SW'(sq_c);

   assign col_p1 = (DW+1)'(col_ff) + (DW+1)'(1);
   assign row_p1 = (DW+1)'(row_ff) + (DW+1)'(1);

   assign best_dr = edge_dist(brow_ff[cmd.corner], eff_h, far_r);
   assign best_dc = edge_dist(bcol_ff[cmd.corner], eff_w, far_c);

   always_comb begin
      if (!found_ff[cmd.corner]) begin
         better = 1'b1;
      end else if (new_ring != ring_ff[cmd.corner]) begin
         better = (new_ring < ring_ff[cmd.corner]);
      end else if (dr_ff != best_dr) begin
         better = (dr_ff < best_dr);
      end else begin
         better = (dc_ff < best_dc);
      end
   end

   assign rsp_taken = rsp_valid_ff && rsp_ready;

   cnfp_isqrt #(
      .CW (CW)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.sqrt_go),
      .operand (d2_ff),
      .done    (sqrt_done),
      .ring    (new_ring)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_height_ff <= DIM_RESET;
         csr_width_ff  <= DIM_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_HEIGHT: csr_height_ff <= csr_data;
            REG_IMAGE_WIDTH:  csr_width_ff  <= csr_data;
         endcase
      end
   end

   // raster position and frame control
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         col_ff  <= '0;
         last_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            last_ff <= req_frame_last;
         end
         if (cmd.clear) begin
            row_ff <= '0;
            col_ff <= '0;
         end else if (cmd.advance) begin
            if (!in_frame) begin
               row_ff <= '0;
               col_ff <= '0;
            end else if (col_p1 >= (DW+1)'(eff_w)) begin
               col_ff <= '0;
               row_ff <= (row_p1 >= (DW+1)'(eff_h)) ? '0 : CW'(row_p1);
            end else begin
               col_ff <= CW'(col_p1);
            end
         end
      end
   end

   // distance and squared-distance stage
   always_ff @(posedge clock) begin
      if (cmd.square) begin
         dr_ff <= dr_now;
         dc_ff <= dc_now;
         d2_ff <= d2_in;
      end
   end

   // per-corner best keys
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NC; k++) begin
            found_ff[k] <= 1'b0;
         end
      end else if (cmd.clear) begin
         for (int k = 0; k < NC; k++) begin
            found_ff[k] <= 1'b0;
         end
      end else if (cmd.update && better) begin
         found_ff[cmd.corner] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update && better) begin
         ring_ff[cmd.corner] <= new_ring;
         brow_ff[cmd.corner] <= row_ff;
         bcol_ff[cmd.corner] <= col_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_taken) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_corner_id_ff   <= cmd.corner;
         rsp_found_ff       <= found_ff[cmd.corner];
         rsp_hit_row_ff     <= found_ff[cmd.corner] ? OUT_POS_W'(brow_ff[cmd.corner]) : '0;
         rsp_hit_col_ff     <= found_ff[cmd.corner] ? OUT_POS_W'(bcol_ff[cmd.corner]) : '0;
         rsp_last_result_ff <= (cmd.corner == CORNER_LAST);
      end
   end

   assign status.fg_pixel   = in_frame && req_pixel_on;
   assign status.sqrt_done  = sqrt_done;
   assign status.frame_last = last_ff;
   assign status.rsp_taken  = rsp_taken;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_corner_id   = rsp_corner_id_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_hit_row     = rsp_hit_row_ff;
   assign rsp_hit_col     = rsp_hit_col_ff;
   assign rsp_last_result = rsp_last_result_ff;

endmodule

[rtl/corner_nearest_foreground_pixel.sv]
// Top level of the corner-nearest foreground pixel finder.
//
//   channel | ports                                              | handshake
//   --------+----------------------------------------------------+---------------
//   req     | req_pixel_on, req_frame_last                       | valid/ready
//   rsp     | rsp_corner_id, rsp_found, rsp_hit_row/col, last    | valid/ready
//   csr     | csr_index, csr_data                                | csr_wr_en only
//
// Background or out-of-frame pixel: accept, then position step.
// Foreground pixel: accept, then square, root start and root wait for each corner on the
// shared bit-serial ring (ceiling square root) unit, visited once per corner, then position step.
// Frame end: four results, each loaded and then held until taken; rsp_ready low stretches each one.
// Synchronous active-high reset; height and width return to 60, all corners cleared.
module corner_nearest_foreground_pixel
   import cnfp_pkg::*;
#(
   parameter int MAX_DIM = MAX_DIM_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_pixel_on,
   input  logic                 req_frame_last,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CORNER_W-1:0]  rsp_corner_id,
   output logic                 rsp_found,
   output logic [OUT_POS_W-1:0] rsp_hit_row,
   output logic [OUT_POS_W-1:0] rsp_hit_col,
   output logic                 rsp_last_result,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data
);

   cnfp_cmd_type    cmd;
   cnfp_status_type status;

   cnfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cnfp_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_pixel_on    (req_pixel_on),
      .req_frame_last  (req_frame_last),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_corner_id   (rsp_corner_id),
      .rsp_found       (rsp_found),
      .rsp_hit_row     (rsp_hit_row),
      .rsp_hit_col     (rsp_hit_col),
      .rsp_last_result (rsp_last_result)
   );

endmodule

[rtl/cnfp_checker.sv]
// Port-level checks for the corner finder, bound to the top level.
`include "corner_nearest_foreground_pixel_assert.svh"

module cnfp_checker
   import cnfp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [CORNER_W-1:0]  rsp_corner_id,
   input logic                 rsp_found,
   input logic [OUT_POS_W-1:0] rsp_hit_row,
   input logic [OUT_POS_W-1:0] rsp_hit_col,
   input logic                 rsp_last_result
);

   // no new pixel while the corner results drain
   `CNFP_ASSERT_NOW(a_no_req_during_drain, rsp_valid, !req_ready)

   // an empty corner reports position zero
   `CNFP_ASSERT_NOW(a_empty_zero, rsp_valid && !rsp_found, rsp_hit_row == '0 && rsp_hit_col == '0)

   // last flag marks exactly the bottom-right corner
   `CNFP_ASSERT_NOW(a_last_is_fourth, rsp_valid, rsp_last_result == (rsp_corner_id == CORNER_LAST))

   // a stalled result stays valid with its corner id and row held
   `CNFP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_corner_id) && $stable(rsp_hit_row))

endmodule

bind corner_nearest_foreground_pixel cnfp_checker u_cnfp_checker (.*);

[test/corner_nearest_foreground_pixel_tb.sv]
// Self-checking testbench for the corner-nearest foreground pixel finder.
module corner_nearest_foreground_pixel_tb;
   import cnfp_pkg::*;

   localparam int DIM_LIMIT     = 64;
   localparam int ITEM_TARGET   = 470;
   localparam int SETTLE_CYCLES = 64;
   localparam int LONG_HOLD     = 300;
   localparam int QUIET_LIMIT   = 4000;

   typedef enum logic [CORNER_W-1:0] {
      TOP_LEFT, BOTTOM_LEFT, TOP_RIGHT, BOTTOM_RIGHT
   } corner_type;

   typedef struct packed {
      logic pixel_on;
      logic frame_last;
   } pixel_type;

   typedef struct packed {
      logic [CORNER_W-1:0]  corner_id;
      logic                 found;
      logic [OUT_POS_W-1:0] hit_row;
      logic [OUT_POS_W-1:0] hit_col;
      logic                 last_result;
   } corner_hit_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_pixel_on   = 1'b0;
   logic                 req_frame_last = 1'b0;
   logic                 rsp_ready      = 1'b0;
   logic                 csr_wr_en      = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index      = '0;
   logic [CFG_W-1:0]     csr_data       = '0;
   logic                 req_ready;
   logic                 rsp_valid;
   logic [CORNER_W-1:0]  rsp_corner_id;
   logic                 rsp_found;
   logic [OUT_POS_W-1:0] rsp_hit_row;
   logic [OUT_POS_W-1:0] rsp_hit_col;
   logic                 rsp_last_result;

   corner_nearest_foreground_pixel #(.MAX_DIM(DIM_LIMIT)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_pixel_on    (req_pixel_on),
      .req_frame_last  (req_frame_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_corner_id   (rsp_corner_id),
      .rsp_found       (rsp_found),
      .rsp_hit_row     (rsp_hit_row),
      .rsp_hit_col     (rsp_hit_col),
      .rsp_last_result (rsp_last_result),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor copy of registers and per-corner state
   logic [CFG_W-1:0] height_reg = DIM_RESET;
   logic [CFG_W-1:0] width_reg  = DIM_RESET;
   int row_pos = 0;
   int col_pos = 0;
   bit kept[4];
   int kept_ring[4];
   int kept_row[4];
   int kept_col[4];

   pixel_type      pixel_queue[$];
   corner_hit_type corner_results_due[$];
   pixel_type      queued_px;

   bit req_taken = 1'b0;
   bit rsp_taken = 1'b0;
   bit long_hold_go = 1'b0;
   int hold_count = 0;
   int stall_left = 0;
   int stall_mode = 0;
   int burst_left = 0;
   int gap_left = 0;
   int quiet_cycles = 0;

   int mismatches = 0;
   int pixels_queued = 0;
   int frames_done = 0;
   int results_seen = 0;
   int hits_seen = 0;
   int reg_writes = 0;

   function automatic int clamp_dim(input logic [CFG_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > DIM_LIMIT) return DIM_LIMIT;
      return int'(raw);
   endfunction

   function automatic int edge_gap(input int pos, input int span, input bit from_far);
      if (!from_far) return pos;
      return (pos <= span - 1) ? span - 1 - pos : 0;
   endfunction

   // ceiling square root of the squared distance, never below 1
   function automatic int ring_radius(input int dr, input int dc);
      int sq;
      int r;
      sq = dr * dr + dc * dc;
      r = 0;
      while (r * r < sq) r++;
      return (r < 1) ? 1 : r;
   endfunction

   function automatic void track_pixel(input pixel_type px);
      int h, w, dr, dc, rg, br, bc;
      bit far_r, far_c, better;
      corner_hit_type hit;
      h = clamp_dim(height_reg);
      w = clamp_dim(width_reg);
      if (row_pos < h && col_pos < w) begin
         if (px.pixel_on) begin
            for (int k = 0; k < 4; k++) begin
               far_r = (k == BOTTOM_LEFT || k == BOTTOM_RIGHT);
               far_c = (k == TOP_RIGHT || k == BOTTOM_RIGHT);
               dr = edge_gap(row_pos, h, far_r);
               dc = edge_gap(col_pos, w, far_c);
               rg = ring_radius(dr, dc);
               if (!kept[k]) begin
                  better = 1'b1;
               end else begin
                  br = edge_gap(kept_row[k], h, far_r);
                  bc = edge_gap(kept_col[k], w, far_c);
                  if (rg != kept_ring[k]) better = rg < kept_ring[k];
                  else if (dr != br) better = dr < br;
                  else better = dc < bc;
               end
               if (better) begin
                  kept[k] = 1'b1;
                  kept_ring[k] = rg;
                  kept_row[k] = row_pos;
                  kept_col[k] = col_pos;
               end
            end
         end
         if (col_pos + 1 >= w) begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
         end else begin
            col_pos++;
         end
      end else begin
         row_pos = 0;
         col_pos = 0;
      end
      if (px.frame_last) begin
         frames_done++;
         for (int k = 0; k < 4; k++) begin
            hit.corner_id = CORNER_W'(k);
            hit.found = kept[k];
            hit.hit_row = kept[k] ? OUT_POS_W'(kept_row[k]) : '0;
            hit.hit_col = kept[k] ? OUT_POS_W'(kept_col[k]) : '0;
            hit.last_result = (k == BOTTOM_RIGHT);
            corner_results_due.insert(corner_results_due.size(), hit);
            kept[k] = 1'b0;
            kept_ring[k] = 0;
            kept_row[k] = 0;
            kept_col[k] = 0;
         end
         row_pos = 0;
         col_pos = 0;
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_result();
      corner_hit_type want;
      results_seen++;
      if (rsp_found === 1'b1) hits_seen++;
      if (corner_results_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result for corner %0d", rsp_corner_id));
         return;
      end
      want = corner_results_due.pop_front();
      if (rsp_corner_id !== want.corner_id)
         report_mismatch($sformatf("corner_id %0d, want %0d", rsp_corner_id, want.corner_id));
      if (rsp_found !== want.found)
         report_mismatch($sformatf("corner %0d found %b, want %b",
                                   want.corner_id, rsp_found, want.found));
      if (rsp_hit_row !== want.hit_row)
         report_mismatch($sformatf("corner %0d hit_row %0d, want %0d",
                                   want.corner_id, rsp_hit_row, want.hit_row));
      if (rsp_hit_col !== want.hit_col)
         report_mismatch($sformatf("corner %0d hit_col %0d, want %0d",
                                   want.corner_id, rsp_hit_col, want.hit_col));
      if (rsp_last_result !== want.last_result)
         report_mismatch($sformatf("corner %0d last_result %b, want %b",
                                   want.corner_id, rsp_last_result, want.last_result));
   endtask

   // monitor: sample both channels, predict, check, watchdog
   always @(posedge clock) begin
      req_taken = !reset && req_valid && req_ready;
      rsp_taken = !reset && rsp_valid && rsp_ready;
      if (rsp_taken) check_result();
      if (req_taken) track_pixel('{pixel_on: req_pixel_on, frame_last: req_frame_last});
      if (req_taken || rsp_taken || csr_wr_en) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // pixel driver: bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            queued_px = pixel_queue.pop_front();
            req_valid <= 1'b1;
            req_pixel_on <= queued_px.pixel_on;
            req_frame_last <= queued_px.frame_last;
            if (burst_left > 0) begin
               burst_left <= burst_left - 1;
            end else begin
               burst_left <= $urandom_range(1, 24);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver: one long hold-off, otherwise stall patterns
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_hold_go && hold_count < LONG_HOLD) begin
         rsp_ready <= 1'b0;
         hold_count <= hold_count + 1;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 40);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= $urandom_range(0, 1) == 1;
            2: rsp_ready <= $urandom_range(0, 3) == 0;
            default: rsp_ready <= $urandom_range(0, 3) != 0;
         endcase
      end
   end

   task automatic add_pixel(input logic on, input logic last);
      pixel_type px;
      @(posedge clock);
      px.pixel_on = on;
      px.frame_last = last;
      pixel_queue.insert(pixel_queue.size(), px);
      pixels_queued++;
   endtask

   task automatic wait_drained();
      do @(posedge clock); while (pixel_queue.size() != 0 || req_valid);
      do @(negedge clock); while (corner_results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      if (idx == REG_IMAGE_HEIGHT) height_reg = val;
      else width_reg = val;
      reg_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_frame(input bit whole);
      int span, count, pct;
      span = clamp_dim(height_reg) * clamp_dim(width_reg);
      if (whole) count = span;
      else if ($urandom_range(0, 1) == 0) count = $urandom_range(1, span);
      else count = span + $urandom_range(1, span + 2);
      // keep the total close to the target
      if (pixels_queued + count > ITEM_TARGET + 8) count = ITEM_TARGET + 8 - pixels_queued;
      case ($urandom_range(0, 4))
         0: pct = 0;
         1: pct = 5;
         2: pct = 25;
         3: pct = 60;
         default: pct = 100;
      endcase
      for (int i = 0; i < count; i++)
         add_pixel($urandom_range(0, 99) < pct, i == count - 1);
   endtask

   initial begin
      int h_raw, w_raw;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset dimensions: corner pixel lit, then a frame with nothing lit
      add_pixel(1'b1, 1'b0);
      add_pixel(1'b0, 1'b0);
      add_pixel(1'b1, 1'b1);
      add_pixel(1'b0, 1'b0);
      add_pixel(1'b0, 1'b1);
      wait_drained();

      // zero dims act as 1x1: single pixel is every corner, then position wrap
      write_reg(REG_IMAGE_HEIGHT, '0);
      write_reg(REG_IMAGE_WIDTH, '0);
      add_pixel(1'b1, 1'b1);
      add_pixel(1'b0, 1'b0);
      add_pixel(1'b1, 1'b0);
      add_pixel(1'b0, 1'b1);
      wait_drained();

      // shrink height mid-frame so the position falls outside the frame
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(4));
      write_reg(REG_IMAGE_WIDTH, CFG_W'(4));
      for (int i = 0; i < 10; i++) add_pixel(i == 6 || i == 9, 1'b0);
      wait_drained();
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
      add_pixel(1'b1, 1'b0);
      add_pixel(1'b0, 1'b0);
      add_pixel(1'b1, 1'b1);
      wait_drained();

      // thin frames at the largest size
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(1));
      write_reg(REG_IMAGE_WIDTH, CFG_W'(127));
      send_frame(1'b1);
      wait_drained();
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(DIM_LIMIT));
      write_reg(REG_IMAGE_WIDTH, CFG_W'(1));
      send_frame(1'b1);
      wait_drained();

      // back-to-back small frames against a stalled receiver
      write_reg(REG_IMAGE_HEIGHT, CFG_W'(2));
      write_reg(REG_IMAGE_WIDTH, CFG_W'(2));
      @(posedge clock);
      long_hold_go = 1'b1;
      repeat (6) send_frame(1'b1);

      while (pixels_queued < ITEM_TARGET) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_drained();
            case ($urandom_range(0, 5))
               0: begin
                  h_raw = $urandom_range(65, 127);
                  w_raw = $urandom_range(0, 2);
               end
               1: begin
                  h_raw = $urandom_range(0, 2);
                  w_raw = $urandom_range(9, 127);
               end
               default: begin
                  h_raw = $urandom_range(0, 8);
                  w_raw = $urandom_range(0, 8);
               end
            endcase
            write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_raw));
            write_reg(REG_IMAGE_WIDTH, CFG_W'(w_raw));
         end
         send_frame($urandom_range(0, 4) != 0);
      end
      wait_drained();

      $display("Covered %0d pixels in %0d frames with %0d register writes,",
               pixels_queued, frames_done, reg_writes);
      $display("checked %0d corner results, %0d with a hit, %0d mismatches.",
               results_seen, hits_seen, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+rtl
rtl/cnfp_pkg.sv
rtl/cnfp_isqrt.sv
rtl/cnfp_ctrl.sv
rtl/cnfp_dp.sv
rtl/corner_nearest_foreground_pixel.sv
rtl/cnfp_checker.sv
test/corner_nearest_foreground_pixel_tb.sv
